// ===== hdl/tga_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pkg
// shared types and constants of the image byte stream pixel decoder
// ----------------------------------------------------------------------------
package tga_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int FILL_W        = 17;

    localparam logic [2:0] REG_IMAGE_KIND    = 3'd0;
    localparam logic [2:0] REG_RLE_ON        = 3'd1;
    localparam logic [2:0] REG_PIXEL_BYTES   = 3'd2;
    localparam logic [2:0] REG_PAL_FIRST     = 3'd3;
    localparam logic [2:0] REG_PAL_LENGTH    = 3'd4;
    localparam logic [2:0] REG_PAL_ENTRY     = 3'd5;
    localparam logic [2:0] REG_PIXEL_TOTAL   = 3'd6;

    localparam logic [1:0] KIND_PALETTE   = 2'd0;
    localparam logic [1:0] KIND_GRAYSCALE = 2'd2;

    localparam logic [7:0] COUNT_MASK  = 8'h7F;
    localparam logic [7:0] REPEAT_FLAG = 8'h80;

    // one classified beat from front to back
    typedef struct packed {
        logic        emit;
        logic [31:0] raw;
        logic [7:0]  run;
        logic        is_pal;
        logic        is_gray;
        logic        wide_idx;
        logic        last;
    } tga_cmd_t;

endpackage : tga_pkg
`default_nettype wire

// ===== hdl/tga_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_front
// byte parser: map load, packet headers, pixel assembly, run clamp, counts
// ----------------------------------------------------------------------------
module tga_front
    import tga_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output tga_cmd_t               q_cmd,
    output logic                   pal_we,
    output logic [PAL_AW-1:0]      pal_waddr,
    output logic [31:0]            pal_wdata,
    output logic [15:0]            pal_first,
    output logic [15:0]            pal_length,
    output logic [31:0]            pix_total,
    output logic [31:0]            pix_emitted
);

    logic [1:0]  kind_reg;
    logic        rle_reg;
    logic [2:0]  pbytes_reg;
    logic [15:0] first_reg, length_reg;
    logic [2:0]  ebytes_reg;
    logic [31:0] total_reg;

    logic              load_reg, ended_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [31:0]       asm_reg;
    logic [1:0]        pos_reg;
    logic [7:0]        remain_reg;
    logic              repeat_reg;
    logic [31:0]       emitted_reg;

    logic        take, in_load;
    logic [2:0]  eb, nb;
    logic [31:0] asm_next, masked_e, masked_p;
    logic        entry_end, pix_end, active, is_hdr;
    logic [31:0] due, run32;
    logic [7:0]  run;
    logic [31:0] emitted_next;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full && !ended_reg;
    assign in_load  = load_reg && ({1'b0, length_reg} > fill_reg);

    always_comb
    begin
        eb = (ebytes_reg < 3'd2) ? 3'd2 : ((ebytes_reg > 3'd4) ? 3'd4 : ebytes_reg);
        nb = (pbytes_reg == 3'd0) ? 3'd1 : ((pbytes_reg > 3'd4) ? 3'd4 : pbytes_reg);
        asm_next = (in_load || load_reg == 1'b0) ? asm_reg : asm_reg;
        if (load_reg && !in_load)
            asm_next = 32'h0;
        if (load_reg && !in_load)
            asm_next = asm_next | 32'(data_byte);
        else
            asm_next = asm_reg | (32'(data_byte) << {pos_reg, 3'b000});
        masked_e = asm_next;
        if (eb == 3'd2) masked_e = asm_next & 32'h0000_FFFF;
        else if (eb == 3'd3) masked_e = asm_next & 32'h00FF_FFFF;
        masked_p = asm_next;
        if (nb == 3'd1) masked_p = asm_next & 32'h0000_00FF;
        else if (nb == 3'd2) masked_p = asm_next & 32'h0000_FFFF;
        else if (nb == 3'd3) masked_p = asm_next & 32'h00FF_FFFF;
    end

    logic [1:0] pos_eff;
    assign pos_eff   = (load_reg && !in_load) ? 2'd0 : pos_reg;
    assign entry_end = ({1'b0, pos_reg} + 3'd1) >= eb;
    assign pix_end   = ({1'b0, pos_eff} + 3'd1) >= nb;
    assign active    = !in_load && (emitted_reg < total_reg);
    assign is_hdr    = active && rle_reg && (remain_reg == 8'd0);
    assign due       = total_reg - emitted_reg;

    always_comb
    begin
        run32 = 32'd1;
        if (rle_reg && repeat_reg)
            run32 = {24'd0, remain_reg};
        if (run32 > due)
            run32 = due;
    end
    assign run = run32[7:0];
    assign emitted_next = emitted_reg + run32;

    logic pix_out;
    assign pix_out = active && !is_hdr && pix_end;

    always_comb
    begin
        q_push         = take && (pix_out || (last_byte && emitted_reg < total_reg));
        q_cmd.emit     = pix_out;
        q_cmd.raw      = masked_p;
        q_cmd.run      = pix_out ? run : 8'd0;
        q_cmd.is_pal   = kind_reg == KIND_PALETTE;
        q_cmd.is_gray  = kind_reg == KIND_GRAYSCALE;
        q_cmd.wide_idx = nb == 3'd2;
        q_cmd.last     = last_byte && ((pix_out ? emitted_next : emitted_reg) < total_reg);
        pal_we         = take && in_load && entry_end && (fill_reg < FILL_W'(PALETTE_DEPTH));
        pal_waddr      = fill_reg[PAL_AW-1:0];
        pal_wdata      = masked_e;
    end

    assign pal_first   = first_reg;
    assign pal_length  = length_reg;
    assign pix_total   = total_reg;
    assign pix_emitted = pix_out ? emitted_next : emitted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= 2'd1;
            rle_reg    <= 1'b0;
            pbytes_reg <= 3'd3;
            first_reg  <= 16'd0;
            length_reg <= 16'd0;
            ebytes_reg <= 3'd3;
            total_reg  <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_KIND:  kind_reg   <= cfg_data[1:0];
                REG_RLE_ON:      rle_reg    <= cfg_data[0];
                REG_PIXEL_BYTES: pbytes_reg <= cfg_data[2:0];
                REG_PAL_FIRST:   first_reg  <= cfg_data[15:0];
                REG_PAL_LENGTH:  length_reg <= cfg_data[15:0];
                REG_PAL_ENTRY:   ebytes_reg <= cfg_data[2:0];
                REG_PIXEL_TOTAL: total_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg    <= 1'b1;
            ended_reg   <= 1'b0;
            fill_reg    <= '0;
            asm_reg     <= 32'd0;
            pos_reg     <= 2'd0;
            remain_reg  <= 8'd0;
            repeat_reg  <= 1'b0;
            emitted_reg <= 32'd0;
        end
        else if (take)
        begin
            if (last_byte)
                ended_reg <= 1'b1;
            if (in_load)
            begin
                if (entry_end)
                begin
                    fill_reg <= fill_reg + 1'b1;
                    asm_reg  <= 32'd0;
                    pos_reg  <= 2'd0;
                end
                else
                begin
                    asm_reg <= asm_next;
                    pos_reg <= pos_reg + 2'd1;
                end
            end
            else
            begin
                load_reg <= 1'b0;
                if (active)
                begin
                    if (is_hdr)
                    begin
                        remain_reg <= (data_byte & COUNT_MASK) + 8'd1;
                        repeat_reg <= (data_byte & REPEAT_FLAG) != 8'd0;
                        asm_reg    <= 32'd0;
                        pos_reg    <= 2'd0;
                    end
                    else if (pix_end)
                    begin
                        if (rle_reg)
                            remain_reg <= repeat_reg ? 8'd0 : remain_reg - 8'd1;
                        emitted_reg <= emitted_next;
                        asm_reg     <= 32'd0;
                        pos_reg     <= 2'd0;
                    end
                    else
                    begin
                        asm_reg <= asm_next;
                        pos_reg <= pos_eff + 2'd1;
                    end
                end
                else if (load_reg)
                begin
                    asm_reg <= 32'd0;
                    pos_reg <= 2'd0;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) ended_reg |=> !q_push)
        else $error("beat pushed after stream end");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_cmd.emit) |-> (q_cmd.run != 8'd0))
        else $error("pixel beat with zero run");
    assert property (@(posedge clk) disable iff (!rst_n) pal_we |-> in_load)
        else $error("map write outside load");

endmodule : tga_front
`default_nettype wire

// ===== hdl/tga_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_back
// command register, colour map lookup and two-entry result queue
// ----------------------------------------------------------------------------
module tga_back
    import tga_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_push,
    input  tga_cmd_t               q_cmd,
    input  wire logic              done_in,
    output logic                   q_full,
    input  wire logic              pal_we,
    input  wire logic [PAL_AW-1:0] pal_waddr,
    input  wire logic [31:0]       pal_wdata,
    input  wire logic [15:0]       pal_first,
    input  wire logic [15:0]       pal_length,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            pixel_value,
    output logic [7:0]             run_length,
    output logic                   index_miss,
    output logic                   image_done,
    output logic                   truncated
);

    logic [31:0] mem [PALETTE_DEPTH];
    logic [31:0] rd_reg;

    // stage 1: lookup
    logic        s1_v_reg;
    tga_cmd_t    s1_reg;
    logic        s1_miss_reg, s1_done_reg;

    // two-entry output queue
    logic [42:0] fifo_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    logic [15:0] idx, off;
    logic        miss;
    logic        pop;
    assign idx  = q_cmd.wide_idx ? q_cmd.raw[15:0] : {8'd0, q_cmd.raw[7:0]};
    assign off  = idx - pal_first;
    assign miss = !(idx >= pal_first && off < pal_length && {1'b0, off} < 17'(PALETTE_DEPTH));

    // room check counts the beat in flight in stage 1 and the beat leaving
    assign q_full = ({1'b0, cnt_reg} + {2'b0, s1_v_reg} - {2'b0, pop}) >= 3'd2;

    always_ff @(posedge clk)
    begin
        if (pal_we)
            mem[pal_waddr] <= pal_wdata;
        rd_reg <= mem[off[PAL_AW-1:0]];
    end

    logic [31:0] val;
    always_comb
    begin
        if (!s1_reg.emit)
            val = 32'd0;
        else if (s1_reg.is_pal)
            val = s1_miss_reg ? 32'd0 : rd_reg;
        else if (s1_reg.is_gray)
            val = {8'd0, s1_reg.raw[7:0], s1_reg.raw[7:0], s1_reg.raw[7:0]};
        else
            val = s1_reg.raw;
    end

    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign {pixel_value, run_length, index_miss, image_done, truncated} = fifo_reg[rp_reg][42:0]
        ;

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
            fifo_reg[wp_reg] <= {val, s1_reg.run, s1_reg.emit && s1_reg.is_pal && s1_miss_reg,
                                 s1_done_reg, s1_reg.last};
        if (q_push)
        begin
            s1_reg      <= q_cmd;
            s1_miss_reg <= miss;
            s1_done_reg <= done_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            s1_v_reg <= q_push;
            if (s1_v_reg)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, s1_v_reg} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("output queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_miss) |-> (pixel_value == 32'd0))
        else $error("miss with nonzero value");

endmodule : tga_back
`default_nettype wire

// ===== hdl/tga_rle_pixel_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// colour map load and raw / run-length pixel decode of an image byte stream
// ----------------------------------------------------------------------------
// channel | signals                         | direction
// in      | in_valid in_stall data_byte ... | beat in, one byte
// out     | out_valid out_stall pixel_value | beat out, one pixel, run or end flag
// cfg     | cfg_we cfg_index cfg_data       | register write
// one byte a cycle while in_stall is low; a result is registered in the map
// lookup stage and then written to the two-entry output queue, which keeps
// full rate while the receiver takes a beat every cycle
// reset clears counts and sets registers to defaults; map contents are undefined until loaded
// out_stall fills the queue and then stalls the input side
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
    import tga_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      pixel_value,
    output logic [7:0]       run_length,
    output logic             index_miss,
    output logic             image_done,
    output logic             truncated
);

    logic              q_full, q_push, pal_we;
    tga_cmd_t          q_cmd;
    logic [PAL_AW-1:0] pal_waddr;
    logic [31:0]       pal_wdata, pix_total, pix_emitted;
    logic [15:0]       pal_first, pal_length;

    tga_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
        .data_byte, .last_byte, .q_full, .q_push, .q_cmd, .pal_we, .pal_waddr,
        .pal_wdata, .pal_first, .pal_length, .pix_total, .pix_emitted
    );

    tga_back u_back (
        .clk, .rst_n, .q_push, .q_cmd, .done_in(pix_emitted >= pix_total), .q_full,
        .pal_we, .pal_waddr, .pal_wdata, .pal_first, .pal_length, .out_valid,
        .out_stall, .pixel_value, .run_length, .index_miss, .image_done, .truncated
    );

endmodule : tga_rle_pixel_decoder
`default_nettype wire

// ===== tb/tga_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// loads a colour map of more entries than the store holds, then walks a
// directed table and random phases of raw and packet coded pixel data under
// changing register settings; every result beat is checked in order against
// a cycle-free decoder model kept in this bench
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
    import tga_pkg::*;

    localparam logic [1:0] KIND_TRUE = 2'd1;
    localparam logic [1:0] KIND_ODD  = 2'd3;
    localparam int unsigned TOTAL_MAX = 32'd4294836225;
    localparam int unsigned MAP_LOAD = 300;
    localparam int LIMIT = 400000;
    localparam int RANDOM_BYTES = 620;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  run;
        logic        miss;
        logic        done;
        logic        trunc;
    } pixel_res_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_CHECK} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [7:0]  data;
        pixel_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        index_miss;
    logic        image_done;
    logic        truncated;

    tga_rle_pixel_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_value(pixel_value), .run_length(run_length),
        .index_miss(index_miss), .image_done(image_done), .truncated(truncated)
    );

    // decoder model state
    logic [1:0]  m_kind;
    logic        m_rle;
    logic [2:0]  m_pix_bytes;
    logic [15:0] m_first;
    logic [15:0] m_length;
    logic [2:0]  m_entry_bytes;
    logic [31:0] m_total;
    logic [31:0] map_mem [0:PALETTE_DEPTH-1];
    bit          map_loading;
    bit          stream_ended;
    logic [16:0] map_fill;
    logic [31:0] asm_word;
    logic [1:0]  asm_pos;
    logic [7:0]  pkt_left;
    logic        pkt_repeat;
    logic [31:0] px_emitted;

    pixel_res_t pending_pixels[$];
    stim_row_t  dir_rows[$];
    int errors;
    int cycles;
    bit quiet;
    bit hold_req;
    bit hold_done;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors = errors + 1;
    endtask

    function automatic int unsigned clamp_width(input int unsigned v, input int unsigned lo);
        if (v < lo)
            return lo;
        if (v > 4)
            return 4;
        return v;
    endfunction

    function automatic logic [31:0] width_mask(input int unsigned n);
        return (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
    endfunction

    task reg_update(input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            REG_IMAGE_KIND:  m_kind = v[1:0];
            REG_RLE_ON:      m_rle = v[0];
            REG_PIXEL_BYTES: m_pix_bytes = v[2:0];
            REG_PAL_FIRST:   m_first = v[15:0];
            REG_PAL_LENGTH:  m_length = v[15:0];
            REG_PAL_ENTRY:   m_entry_bytes = v[2:0];
            REG_PIXEL_TOTAL: m_total = v;
            default: ;
        endcase
    endtask

    task decode_byte(input logic [7:0] b, input logic lst, output bit got, output pixel_res_t r);
        int unsigned eb;
        int unsigned nb;
        int unsigned idx;
        int unsigned off;
        int unsigned run;
        int unsigned due;
        logic [31:0] raw;
        got = 0;
        r = '0;
        if (!stream_ended)
        begin
            if (map_loading && map_fill >= {1'b0, m_length})
            begin
                map_loading = 0;
                asm_word = '0;
                asm_pos = '0;
            end
            if (map_loading)
            begin
                eb = clamp_width(32'(m_entry_bytes), 2);
                asm_word = asm_word | (32'(b) << (8 * asm_pos));
                if (asm_pos + 1 >= eb)
                begin
                    if (map_fill < PALETTE_DEPTH)
                        map_mem[map_fill[PAL_AW-1:0]] = asm_word & width_mask(eb);
                    map_fill = map_fill + 1'b1;
                    asm_word = '0;
                    asm_pos = '0;
                end
                else
                    asm_pos = asm_pos + 1'b1;
            end
            else if (px_emitted < m_total)
            begin
                if (m_rle && pkt_left == 0)
                begin
                    pkt_left = (b & COUNT_MASK) + 8'd1;
                    pkt_repeat = (b & REPEAT_FLAG) != 0;
                    asm_word = '0;
                    asm_pos = '0;
                end
                else
                begin
                    nb = clamp_width(32'(m_pix_bytes), 1);
                    asm_word = asm_word | (32'(b) << (8 * asm_pos));
                    if (asm_pos + 1 >= nb)
                    begin
                        raw = asm_word & width_mask(nb);
                        run = 1;
                        due = m_total - px_emitted;
                        if (m_kind == KIND_PALETTE)
                        begin
                            idx = (nb == 2) ? 32'(raw[15:0]) : 32'(raw[7:0]);
                            off = idx - 32'(m_first);
                            if (idx >= m_first && off < m_length && off < PALETTE_DEPTH)
                                r.value = map_mem[off[PAL_AW-1:0]];
                            else
                                r.miss = 1'b1;
                        end
                        else if (m_kind == KIND_GRAYSCALE)
                            r.value = {8'h00, raw[7:0], raw[7:0], raw[7:0]};
                        else
                            r.value = raw;
                        if (m_rle)
                        begin
                            if (pkt_repeat)
                            begin
                                run = 32'(pkt_left);
                                pkt_left = '0;
                            end
                            else
                                pkt_left = pkt_left - 1'b1;
                        end
                        if (run > due)
                            run = due;
                        px_emitted = px_emitted + run;
                        asm_word = '0;
                        asm_pos = '0;
                        r.run = run[7:0];
                        r.done = px_emitted >= m_total;
                        r.trunc = lst && px_emitted < m_total;
                        got = 1;
                    end
                    else
                        asm_pos = asm_pos + 1'b1;
                end
            end
            if (lst)
            begin
                stream_ended = 1;
                if (!got && px_emitted < m_total)
                begin
                    r = '0;
                    r.done = px_emitted >= m_total;
                    r.trunc = 1'b1;
                    got = 1;
                end
            end
        end
    endtask

    task cfg_put(input logic [2:0] idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        reg_update(idx, v);
        @(posedge clk);
    endtask

    // lower valid and wait until every pixel is out and the pipe is quiet
    task drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task send_byte(input logic [7:0] b, input logic lst, input bit typed, input pixel_res_t want);
        bit got;
        pixel_res_t r;
        while (!quiet && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, lst, got, r);
        if (typed)
            pending_pixels.push_back(want);
        else if (got)
            pending_pixels.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                report("unexpected beat", pixel_value, 32'd0);
            else
            begin
                pixel_res_t w;
                w = pending_pixels.pop_front();
                if (pixel_value !== w.value)
                    report("pixel_value", pixel_value, w.value);
                if (run_length !== w.run)
                    report("run_length", run_length, w.run);
                if (index_miss !== w.miss)
                    report("index_miss", index_miss, w.miss);
                if (image_done !== w.done)
                    report("image_done", image_done, w.done);
                if (truncated !== w.trunc)
                    report("truncated", truncated, w.trunc);
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
                out_stall <= !quiet && $urandom_range(0, 99) < 22;
        end
    end

    function automatic stim_row_t row_cfg(input logic [2:0] idx, input logic [31:0] v);
        stim_row_t s;
        s.kind = ROW_CFG;
        s.idx = idx;
        s.val = v;
        s.data = '0;
        s.res = '0;
        return s;
    endfunction

    function automatic stim_row_t row_byte(input logic [7:0] b);
        stim_row_t s;
        s = row_cfg(REG_IMAGE_KIND, 0);
        s.kind = ROW_BYTE;
        s.data = b;
        return s;
    endfunction

    function automatic stim_row_t row_check(input logic [7:0] b, input logic [31:0] v,
                                            input logic [7:0] run, input logic miss,
                                            input logic done);
        stim_row_t s;
        s = row_byte(b);
        s.kind = ROW_CHECK;
        s.res = '{value: v, run: run, miss: miss, done: done, trunc: 1'b0};
        return s;
    endfunction

    initial
    begin
        stim_row_t row;
        bit cfg_open;
        int sent;
        int n;
        int k;
        int unsigned nb;
        int unsigned cnt;
        int phase_no;
        logic [7:0] hdr;

        errors = 0;
        cycles = 0;
        quiet = 0;
        hold_req = 0;
        hold_done = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;

        m_kind = KIND_TRUE;
        m_rle = 1'b0;
        m_pix_bytes = 3'd3;
        m_first = '0;
        m_length = '0;
        m_entry_bytes = 3'd3;
        m_total = '0;
        map_loading = 1;
        stream_ended = 0;
        map_fill = '0;
        asm_word = '0;
        asm_pos = '0;
        pkt_left = '0;
        pkt_repeat = 1'b0;
        px_emitted = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // colour map longer than the store, entry width changed part way
        cfg_put(REG_PAL_LENGTH, MAP_LOAD);
        cfg_put(REG_PAL_ENTRY, 32'd2);
        cfg_we <= 1'b0;
        for (k = 0; k < 200; k++)
            send_byte(8'($urandom), 1'b0, 0, '0);
        drain();
        cfg_put(REG_PAL_ENTRY, 32'd4);
        cfg_we <= 1'b0;
        for (k = 0; k < 600; k++)
            send_byte(8'($urandom), 1'b0, 0, '0);
        drain();
        cfg_put(REG_PAL_ENTRY, 32'd7);
        cfg_we <= 1'b0;
        for (k = 0; k < 200; k++)
            send_byte(8'($urandom), 1'b0, 0, '0);

        dir_rows.push_back(row_cfg(REG_IMAGE_KIND, KIND_TRUE));
        dir_rows.push_back(row_cfg(REG_PIXEL_BYTES, 32'd4));
        dir_rows.push_back(row_cfg(REG_PIXEL_TOTAL, 32'd20));
        dir_rows.push_back(row_byte(8'h00));
        dir_rows.push_back(row_byte(8'h00));
        dir_rows.push_back(row_byte(8'h00));
        dir_rows.push_back(row_check(8'h00, 32'h0, 8'd1, 1'b0, 1'b0));
        dir_rows.push_back(row_byte(8'hFF));
        dir_rows.push_back(row_byte(8'hFF));
        dir_rows.push_back(row_byte(8'hFF));
        dir_rows.push_back(row_check(8'hFF, 32'hFFFF_FFFF, 8'd1, 1'b0, 1'b0));
        dir_rows.push_back(row_cfg(REG_IMAGE_KIND, KIND_GRAYSCALE));
        dir_rows.push_back(row_cfg(REG_PIXEL_BYTES, 32'd1));
        dir_rows.push_back(row_check(8'hAB, 32'h00AB_ABAB, 8'd1, 1'b0, 1'b0));
        dir_rows.push_back(row_check(8'h00, 32'h0, 8'd1, 1'b0, 1'b0));
        dir_rows.push_back(row_cfg(REG_IMAGE_KIND, KIND_PALETTE));
        dir_rows.push_back(row_cfg(REG_PIXEL_BYTES, 32'd2));
        dir_rows.push_back(row_cfg(REG_PAL_FIRST, 32'd5));
        // index below the first entry, then one past the store
        dir_rows.push_back(row_byte(8'h03));
        dir_rows.push_back(row_check(8'h00, 32'h0, 8'd1, 1'b1, 1'b0));
        dir_rows.push_back(row_byte(8'h05));
        dir_rows.push_back(row_check(8'h01, 32'h0, 8'd1, 1'b1, 1'b0));
        dir_rows.push_back(row_byte(8'h04));
        dir_rows.push_back(row_byte(8'h01));
        dir_rows.push_back(row_cfg(REG_PIXEL_BYTES, 32'd1));
        dir_rows.push_back(row_cfg(REG_PAL_FIRST, 32'd0));
        dir_rows.push_back(row_byte(8'hFF));
        dir_rows.push_back(row_cfg(REG_IMAGE_KIND, KIND_ODD));
        dir_rows.push_back(row_cfg(REG_PIXEL_BYTES, 32'd0));
        dir_rows.push_back(row_check(8'h5A, 32'h5A, 8'd1, 1'b0, 1'b0));
        dir_rows.push_back(row_cfg(REG_IMAGE_KIND, KIND_TRUE));
        dir_rows.push_back(row_cfg(REG_RLE_ON, 32'd1));
        dir_rows.push_back(row_byte(REPEAT_FLAG | 8'h02));
        dir_rows.push_back(row_check(8'h77, 32'h77, 8'd3, 1'b0, 1'b0));
        dir_rows.push_back(row_byte(8'h01));
        dir_rows.push_back(row_byte(8'h11));
        dir_rows.push_back(row_byte(8'h22));
        // long repeat clamped to the pixels still due, then a byte after done
        dir_rows.push_back(row_byte(8'hFF));
        dir_rows.push_back(row_check(8'h33, 32'h33, 8'd6, 1'b0, 1'b1));
        dir_rows.push_back(row_byte(8'h44));

        cfg_open = 0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain();
                cfg_put(row.idx, row.val);
                cfg_open = 1;
            end
            else
            begin
                if (cfg_open)
                    cfg_we <= 1'b0;
                cfg_open = 0;
                send_byte(row.data, 1'b0, row.kind == ROW_CHECK, row.res);
            end
        end

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_BYTES)
        begin
            drain();
            cfg_put(REG_IMAGE_KIND, $urandom_range(0, 3));
            cfg_put(REG_RLE_ON, $urandom_range(0, 1));
            cfg_put(REG_PIXEL_BYTES,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
            case ($urandom_range(0, 9))
                0: cfg_put(REG_PAL_FIRST, 32'hFFFF);
                1: cfg_put(REG_PAL_FIRST, $urandom_range(0, 16'hFFFF));
                default: cfg_put(REG_PAL_FIRST, $urandom_range(0, 8));
            endcase
            case ($urandom_range(0, 5))
                0: cfg_put(REG_PAL_LENGTH, 32'd0);
                1: cfg_put(REG_PAL_LENGTH, 32'hFFFF);
                2: cfg_put(REG_PAL_LENGTH, $urandom_range(1, 300));
                default: ;
            endcase
            cfg_put(REG_PAL_ENTRY, $urandom_range(0, 7));
            if (phase_no == 3)
                cfg_put(REG_PIXEL_TOTAL, 32'd0);
            else if (phase_no % 12 == 4)
                cfg_put(REG_PIXEL_TOTAL, TOTAL_MAX);
            else
                cfg_put(REG_PIXEL_TOTAL, px_emitted + $urandom_range(1, 150));
            cfg_we <= 1'b0;
            quiet = (phase_no >= 5 && phase_no < 8);
            hold_req = (phase_no == 4);

            n = $urandom_range(20, 90);
            nb = clamp_width(32'(m_pix_bytes), 1);
            k = 0;
            while (k < n)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_byte(8'($urandom), 1'b0, 0, '0);
                    sent++;
                    k++;
                end
                else
                begin
                    cnt = 1;
                    if (m_rle)
                    begin
                        hdr = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(0, 5));
                        if ($urandom_range(0, 1))
                            hdr = hdr | REPEAT_FLAG;
                        cnt = (hdr & REPEAT_FLAG) ? 1 : (hdr & COUNT_MASK) + 1;
                        send_byte(hdr, 1'b0, 0, '0);
                        sent++;
                        k++;
                    end
                    repeat (cnt * nb)
                    begin
                        if (m_kind == KIND_PALETTE && $urandom_range(0, 3) != 0)
                            send_byte(8'($urandom_range(0, 12)), 1'b0, 0, '0);
                        else
                            send_byte(8'($urandom), 1'b0, 0, '0);
                        sent++;
                        k++;
                    end
                end
            end
            phase_no++;
        end

        // stream ends short of the total
        drain();
        cfg_put(REG_RLE_ON, 32'd0);
        cfg_put(REG_PIXEL_BYTES, 32'd1);
        cfg_put(REG_PIXEL_TOTAL, px_emitted + 40);
        cfg_we <= 1'b0;
        send_byte(8'($urandom), 1'b1, 0, '0);
        send_byte(8'($urandom), 1'b0, 0, '0);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tga_pkg.sv
hdl/tga_front.sv
hdl/tga_back.sv
hdl/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_tb.sv
